### rtl/kpd_pkg.sv
// shared types, constants and key decode for the keypad scan debouncer
package kpd_pkg;

    localparam int unsigned COUNT_WIDTH_DEF  = 8;
    localparam int unsigned CFG_WIDTH        = 8;
    localparam logic [7:0]  DEBOUNCE_RST     = 8'd4;
    localparam int unsigned CONTACT_WIDTH    = 16;
    localparam int unsigned IN_TDATA_WIDTH   = 16;
    localparam int unsigned OUT_TDATA_WIDTH  = 8;

    typedef logic [4:0] t_code;

    localparam t_code NOKEY = 5'd16;

    typedef logic [3:0] t_keymap [CONTACT_WIDTH];

    localparam t_keymap KEYMAP = '{
        4'd1,  4'd4,  4'd7,  4'd14,
        4'd2,  4'd5,  4'd8,  4'd0,
        4'd3,  4'd6,  4'd9,  4'd15,
        4'd10, 4'd11, 4'd12, 4'd13
    };

    // lowest set contact wins
    function automatic t_code decode_contacts(input logic [CONTACT_WIDTH-1:0] bits);
        t_code code;
        code = NOKEY;
        for (int i = CONTACT_WIDTH - 1; i >= 0; i--) begin
            if (bits[i]) begin
                code = {1'b0, KEYMAP[i]};
            end
        end
        return code;
    endfunction

endpackage

### rtl/keypad_scan_debounce_core.sv
// keypad scan debouncer top level: input register, key decode, debounce fsm, result register
// path: input register, then result register, between an input transfer and its result on the master side
// throughput: one snapshot per cycle while the master side is ready, set by the input and result register pair
// a full result register stalls the slave side only when the master side is not ready
// reset: synchronous, active low; clears valids, fsm to idle, no key held,
// countdown to zero and debounce count to 4
module keypad_scan_debounce_core
    import kpd_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_WIDTH-1:0]       i_cfg_wdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,   // [15:0] contacts
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata    // [3:0] key_code, [4] key_held, [7:5] zero
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_DETECT  = 2'd1;
    localparam logic [1:0] PH_CHECK   = 2'd2;

    logic [CFG_WIDTH-1:0]     r_debounce;
    logic                     r_in_valid;
    logic [CONTACT_WIDTH-1:0] r_in_data;
    logic                     r_out_valid;
    logic [3:0]               r_out_code;
    logic                     r_out_held;

    logic [1:0]               r_phase;
    logic [1:0]               n_phase;
    t_code                    r_last;
    t_code                    n_last;
    logic [COUNT_WIDTH-1:0]   r_countdown;
    logic [COUNT_WIDTH-1:0]   n_countdown;
    t_code                    r_latched;
    t_code                    n_latched;

    t_code                    code;
    logic                     out_ready;
    logic                     advance;

    assign out_ready     = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_ready;
    assign s_axis_tready = !r_in_valid || out_ready;

    assign code = decode_contacts(r_in_data);

    always_comb begin
        n_phase     = r_phase;
        n_last      = r_last;
        n_countdown = r_countdown;
        n_latched   = r_latched;
        if (code == NOKEY) begin
            n_phase   = PH_IDLE;
            n_last    = NOKEY;
            n_latched = NOKEY;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    n_phase = PH_DETECT;
                    n_last  = code;
                end
                PH_DETECT: begin
                    if (r_last != code) begin
                        n_last = code;
                    end else begin
                        n_phase     = PH_CHECK;
                        n_countdown = COUNT_WIDTH'(r_debounce);
                    end
                end
                PH_CHECK: begin
                    if (r_last != code) begin
                        n_phase = PH_DETECT;
                    end else if (r_countdown != '0) begin
                        n_countdown = r_countdown - COUNT_WIDTH'(1);
                    end else begin
                        n_latched = code;
                        n_phase   = PH_IDLE;
                        n_last    = NOKEY;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= DEBOUNCE_RST;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_last      <= NOKEY;
            r_countdown <= '0;
            r_latched   <= NOKEY;
        end else begin
            if (i_cfg_we) begin
                r_debounce <= i_cfg_wdata;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_phase     <= n_phase;
                r_last      <= n_last;
                r_countdown <= n_countdown;
                r_latched   <= n_latched;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata[CONTACT_WIDTH-1:0];
        end
        if (advance) begin
            r_out_held <= (n_latched != NOKEY);
            r_out_code <= (n_latched != NOKEY) ? n_latched[3:0] : 4'd0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_held, r_out_code};

endmodule

### rtl/kpd_checker.sv
// port-level checker for the keypad scan debouncer, bound to the top level
module kpd_checker
    import kpd_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata
);

    // no result right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:5] == 3'b000))
        else $error("nonzero padding in result");

    // no key held means code zero
    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[4]) |-> (m_axis_tdata[3:0] == 4'd0))
        else $error("key code nonzero while no key held");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // empty pipeline always takes a transfer
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready)) |-> s_axis_tready)
        else $error("slave side stalled with empty pipeline");

endmodule

bind keypad_scan_debounce_core kpd_checker u_kpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
